/* hw/rtl/som_bmu_pkg.sv */
// ----------------------------------------------------------------------------
// som_bmu_pkg
// shared types and constants of the best matching unit search
// ----------------------------------------------------------------------------
`default_nettype none

package som_bmu_pkg;

  localparam int unsigned NumFeat  = 7;
  localparam int unsigned FracBits = 16;

  typedef enum logic [2:0] {
    OP_LOAD_WEIGHT = 3'd0,
    OP_LOAD_EXP    = 3'd1,
    OP_LOAD_RISK   = 3'd2,
    OP_LOAD_SCALE  = 3'd3,
    OP_QUERY       = 3'd4
  } op_e;

  localparam logic CFG_NODE_COUNT   = 1'b0;
  localparam logic CFG_DEFAULT_RISK = 1'b1;

  localparam logic signed [23:0] S24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] S24Min = -24'sh800000;
  localparam logic [27:0] DistMax = 28'hFFFFFFF;

  typedef struct packed {
    logic [2:0]         operation;
    logic [8:0]         node_index;
    logic [2:0]         feature_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] feature_0;
    logic signed [31:0] feature_1;
    logic signed [31:0] feature_2;
    logic signed [31:0] feature_3;
    logic signed [31:0] feature_4;
    logic signed [31:0] feature_5;
    logic signed [31:0] feature_6;
  } req_t;

  typedef struct packed {
    logic signed [31:0] expectancy;
    logic signed [31:0] risk;
    logic [8:0]         best_node;
    logic [27:0]        best_distance;
    logic               status;
  } rsp_t;

  // divider control between top level and divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/som_bmu_div.sv */
// ----------------------------------------------------------------------------
// som_bmu_div
// restoring divider, signed 50 by positive 33 bit, truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module som_bmu_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [49:0] num_i,
  input  wire logic [32:0]        den_i,
  output som_bmu_pkg::div_ctl_t   ctl_o,
  output logic signed [49:0]      quo_o
);
  import som_bmu_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [49:0] num_q, num_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [33:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    trial  = {rem_q[32:0], num_q[49]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      neg_d  = num_i[49];
      num_d  = num_i[49] ? 50'(-num_i) : num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial;
        num_d = {num_q[48:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], num_q[49]};
        num_d = {num_q[48:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd49) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign quo_o = neg_q ? 50'(-num_q) : num_q;

endmodule

`default_nettype wire

/* hw/rtl/som_best_matching_unit.sv */
// ----------------------------------------------------------------------------
// som_best_matching_unit
// self-organizing map best matching unit search with L1 distance
// ----------------------------------------------------------------------------
// Usage: drive req_i and pulse start while busy is low. Loads (weight,
// expectancy, risk, feature scale) pass through a done state and give no
// result. A query first scales each of the seven features with a 50-step
// serial divider (one shared divider; a feature whose range is empty or
// negative skips the divider), then reads one weight per cycle from the
// weight memory, one node row after another, accumulating the L1 distance
// pipelined across nodes. The result is shown on rsp_o for one cycle with
// done_o high. An unloaded model answers with status set. Configuration
// writes on cfg_valid_i/cfg_ready_o are taken while idle. Reset clears the
// scale valid bits, the node count and the state registers; after reset
// the block stays busy while the risk valid memory is cleared. The other
// memories keep no reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module som_best_matching_unit #(
  parameter int unsigned NODES = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire som_bmu_pkg::req_t   req_i,
  output logic                     done_o,
  output som_bmu_pkg::rsp_t        rsp_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [16:0]         cfg_data_i
);
  import som_bmu_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned WA = $clog2(NODES * NumFeat);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVS  = 4'd1;
  localparam logic [3:0] S_DIVW  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;

  logic [23:0] wmem [NODES*NumFeat];
  logic [31:0] emem [NODES];
  logic [31:0] rmem [NODES];
  logic        rpmem [NODES];
  logic signed [31:0] slo_q [NumFeat];
  logic signed [31:0] shi_q [NumFeat];
  logic [NumFeat-1:0] spres_q;
  logic [9:0]  ncount_q;
  logic [16:0] drisk_q;
  logic [NW-1:0] clr_q;

  logic [3:0]  st_q;
  req_t        req_q;
  logic [2:0]  f_q;
  logic signed [23:0] sc_q [NumFeat];
  logic [NW:0] node_q;
  logic [2:0]  ff_q;
  logic [NW:0] cnt;
  logic [WA-1:0] waddr_q;

  logic        v1_q, v2_q;
  logic [NW-1:0] n1_q;
  logic [2:0]  f1_q;
  logic [23:0] w_q;
  logic [27:0] acc_q;
  logic [27:0] bestd_q;
  logic [NW-1:0] best_q;
  logic        have_q;
  logic [31:0] e_q, r_q;
  logic        rp_q;
  rsp_t        rsp_q;
  logic        done_q;

  logic signed [49:0] dnum, dquo;
  logic [32:0]        dden;
  logic               dstart;
  div_ctl_t           dctl;
  logic signed [32:0] rng;
  logic signed [31:0] rawf;

  som_bmu_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .ctl_o(dctl), .quo_o(dquo)
  );

  always_comb begin
    case (f_q)
      3'd0:    rawf = req_q.feature_0;
      3'd1:    rawf = req_q.feature_1;
      3'd2:    rawf = req_q.feature_2;
      3'd3:    rawf = req_q.feature_3;
      3'd4:    rawf = req_q.feature_4;
      3'd5:    rawf = req_q.feature_5;
      default: rawf = req_q.feature_6;
    endcase
  end

  assign rng    = 33'(shi_q[f_q]) - 33'(slo_q[f_q]);
  assign dnum   = 50'(34'(rawf) - 34'(slo_q[f_q])) <<< FracBits;
  assign dden   = rng[32:0];
  assign dstart = (st_q == S_DIVS) && !rng[32] && (rng != '0);
  assign cnt    = (32'(ncount_q) > NODES) ? (NW+1)'(NODES) : (NW+1)'(ncount_q);

  assign busy        = (st_q != S_IDLE);
  assign cfg_ready_o = (st_q == S_IDLE);

  logic signed [24:0] sdiff;
  logic [23:0] adiff;
  logic [28:0] accs;
  logic [27:0] accsat;
  assign sdiff  = 25'($signed(w_q)) - 25'(sc_q[f1_q]);
  assign adiff  = sdiff[24] ? 24'(-sdiff) : sdiff[23:0];
  assign accs   = ((f1_q == 3'd0) ? 29'd0 : 29'(acc_q)) + 29'(adiff);
  assign accsat = accs[28] ? DistMax : accs[27:0];

  always_ff @(posedge clk_i) begin
    if (st_q == S_CLR) begin
      rpmem[clr_q] <= 1'b0;
    end else if (start && !busy) begin
      case (req_i.operation)
        OP_LOAD_WEIGHT: if (32'(req_i.node_index) < NODES
                            && req_i.feature_index < 3'(NumFeat)) begin
          wmem[WA'(32'(req_i.node_index) * NumFeat + 32'(req_i.feature_index))] <=
            (req_i.value_a > 32'(S24Max)) ? S24Max :
            (req_i.value_a < 32'(S24Min)) ? S24Min : req_i.value_a[23:0];
        end
        OP_LOAD_EXP: if (32'(req_i.node_index) < NODES)
          emem[NW'(req_i.node_index)] <= req_i.value_a;
        OP_LOAD_RISK: if (32'(req_i.node_index) < NODES) begin
          rmem[NW'(req_i.node_index)]  <= req_i.value_a;
          rpmem[NW'(req_i.node_index)] <= 1'b1;
        end
        default: ;
      endcase
    end
    w_q  <= wmem[waddr_q];
    e_q  <= emem[best_q];
    r_q  <= rmem[best_q];
    rp_q <= rpmem[best_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_CLR;
      clr_q    <= '0;
      spres_q  <= '0;
      ncount_q <= '0;
      drisk_q  <= 17'd3277;
      done_q   <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      v2_q   <= v1_q;
      v1_q   <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_NODE_COUNT) ncount_q <= cfg_data_i[9:0];
        else drisk_q <= cfg_data_i;
      end
      unique case (st_q)
        S_IDLE: if (start) begin
          if (req_i.operation == OP_LOAD_SCALE && req_i.feature_index < 3'(NumFeat))
            spres_q[req_i.feature_index] <= 1'b1;
          if (req_i.operation == OP_QUERY) begin
            st_q <= (cnt == '0 || !(&spres_q)) ? S_OUT : S_DIVS;
          end else st_q <= S_DONE;
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NW'(NODES - 1)) st_q <= S_IDLE;
        end
        S_DIVS: begin
          if (!dctl.start) begin
            sc_q[f_q] <= 24'sh1 <<< (FracBits - 1);
            if (f_q == 3'(NumFeat - 1)) st_q <= S_SCAN;
          end else st_q <= S_DIVW;
        end
        S_DIVW: if (!dctl.busy) begin
          sc_q[f_q] <= (dquo > 50'(S24Max)) ? S24Max :
                       (dquo < 50'(S24Min)) ? S24Min : dquo[23:0];
          st_q <= (f_q == 3'(NumFeat - 1)) ? S_SCAN : S_DIVS;
        end
        S_SCAN: begin
          v1_q <= 1'b1;
          if (node_q == cnt - 1'b1 && ff_q == 3'(NumFeat - 1)) st_q <= S_DRAIN;
        end
        S_DRAIN: if (!v1_q && !v2_q) st_q <= S_RD;
        S_RD: st_q <= S_OUT;
        S_OUT: begin
          done_q <= 1'b1;
          st_q   <= S_IDLE;
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q   <= req_i;
      f_q     <= '0;
      node_q  <= '0;
      ff_q    <= '0;
      waddr_q <= '0;
      have_q  <= 1'b0;
      if (req_i.operation == OP_LOAD_SCALE && req_i.feature_index < 3'(NumFeat)) begin
        slo_q[req_i.feature_index] <= req_i.value_a;
        shi_q[req_i.feature_index] <= req_i.value_b;
      end
    end
    if ((st_q == S_DIVS && !dctl.start) || (st_q == S_DIVW && !dctl.busy))
      f_q <= f_q + 3'd1;
    if (st_q == S_SCAN) begin
      n1_q <= node_q[NW-1:0];
      f1_q <= ff_q;
      waddr_q <= waddr_q + 1'b1;
      if (ff_q == 3'(NumFeat - 1)) begin
        ff_q <= '0;
        node_q <= node_q + 1'b1;
      end else ff_q <= ff_q + 3'd1;
    end
    if (v1_q) begin
      acc_q <= accsat;
      if (f1_q == 3'(NumFeat - 1) && (!have_q || accsat < bestd_q)) begin
        bestd_q <= accsat;
        best_q  <= n1_q;
        have_q  <= 1'b1;
      end
    end
    if (st_q == S_IDLE) best_q <= '0;
    if (st_q == S_OUT) begin
      if (!have_q) begin
        rsp_q <= '{expectancy: '0, risk: 32'(drisk_q), best_node: '0,
                   best_distance: '0, status: 1'b1};
      end else begin
        rsp_q <= '{expectancy: e_q, risk: rp_q ? r_q : 32'(drisk_q),
                   best_node: 9'(best_q), best_distance: bestd_q, status: 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT) |=> done_o) else $error("result strobe missing");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o) else $error("config open while busy");

endmodule

`default_nettype wire
